@@ hdl/pgf_pkg.sv @@
// shared types and constants of the pairwise gravity force unit
`timescale 1ns / 1ps

package pgf_pkg;

    localparam int IN_BITS   = 32;   // width of a position field
    localparam int MASS_BITS = 32;   // width of a mass field
    localparam int G_BITS    = 32;   // width of the gravity constant register
    localparam int SQ_SHIFT  = 32;   // distance squared moved to Q.32 before the root
    localparam int NUM_SHIFT = 56;   // aligns G*m*m*delta over r^3 to Q32.32
    localparam int QB        = 64;   // quotient bits = force width
    localparam int DIG       = 16;   // multiplier digit width

    localparam logic [G_BITS-1:0] G_RESET = 32'd1678;
    localparam logic [QB-1:0]     F_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [QB-1:0]     F_MIN   = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic signed [IN_BITS-1:0] own_x;
        logic signed [IN_BITS-1:0] own_y;
        logic [MASS_BITS-1:0]      own_mass;
        logic signed [IN_BITS-1:0] other_x;
        logic signed [IN_BITS-1:0] other_y;
        logic [MASS_BITS-1:0]      other_mass;
    } t_pgf_in;

    typedef struct packed {
        logic signed [QB-1:0] force_x;
        logic signed [QB-1:0] force_y;
        logic                 saturated;
    } t_pgf_out;

endpackage

@@ hdl/pgf_mul.sv @@
// pipelined unsigned multiplier, one 16-bit digit of a per stage
`timescale 1ns / 1ps

module pgf_mul #(
    parameter int WA = 64,
    parameter int WB = 32,
    parameter int WS = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    input  logic [WS-1:0]    i_side,
    output logic             o_valid,
    output logic [WA+WB-1:0] o_p,
    output logic [WS-1:0]    o_side
);
    import pgf_pkg::*;

    localparam int ND  = (WA + DIG - 1) / DIG;
    localparam int WAP = ND * DIG;
    localparam int WP  = WA + WB;

    logic            r_v    [ND];
    logic [WP-1:0]   r_acc  [ND];
    logic [WAP-1:0]  r_a    [ND];
    logic [WB-1:0]   r_b    [ND];
    logic [WS-1:0]   r_side [ND];

    for (genvar k = 0; k < ND; k++) begin : g_st
        logic            v_in;
        logic [WP-1:0]   acc_in;
        logic [WAP-1:0]  a_in;
        logic [WB-1:0]   b_in;
        logic [WS-1:0]   s_in;
        logic [WB+DIG-1:0] pp;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign acc_in = '0;
            assign a_in   = WAP'(i_a);
            assign b_in   = i_b;
            assign s_in   = i_side;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign acc_in = r_acc[k-1];
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign s_in   = r_side[k-1];
        end

        assign pp = a_in[DIG*k +: DIG] * b_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_acc[k]  <= acc_in + (WP'(pp) << (DIG * k));
            r_a[k]    <= a_in;
            r_b[k]    <= b_in;
            r_side[k] <= s_in;
        end
    end

    assign o_valid = r_v[ND-1];
    assign o_p     = r_acc[ND-1];
    assign o_side  = r_side[ND-1];

endmodule

@@ hdl/pgf_sqrt.sv @@
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module pgf_sqrt #(
    parameter int WN = 97,
    parameter int WS = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [WN-1:0]       i_n,
    input  logic [WS-1:0]       i_side,
    output logic                o_valid,
    output logic [(WN+1)/2-1:0] o_root,
    output logic [WS-1:0]       o_side
);
    localparam int RW = (WN + 1) / 2;
    localparam int TW = 2 * RW + 1;

    logic          r_v    [RW];
    logic [WN-1:0] r_rem  [RW];
    logic [RW-1:0] r_q    [RW];
    logic [WS-1:0] r_side [RW];

    for (genvar j = 0; j < RW; j++) begin : g_st
        localparam int B = RW - 1 - j;
        logic          v_in;
        logic [WN-1:0] rem_in;
        logic [RW-1:0] q_in;
        logic [WS-1:0] s_in;
        logic [TW-1:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_n;
            assign q_in   = '0;
            assign s_in   = i_side;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign s_in   = r_side[j-1];
        end

        // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
        assign trial = (TW'(q_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign ge    = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= ge ? WN'(TW'(rem_in) - trial) : rem_in;
            r_q[j]    <= ge ? (q_in | (RW'(1) << B)) : q_in;
            r_side[j] <= s_in;
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_q[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

@@ hdl/pgf_div.sv @@
// pipelined restoring divider, 64 quotient bits plus overflow flag
`timescale 1ns / 1ps

module pgf_div #(
    parameter int WNUM = 184,
    parameter int WDEN = 147,
    parameter int WS   = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [WNUM-1:0]       i_num,
    input  logic [WDEN-1:0]       i_den,
    input  logic [WS-1:0]         i_side,
    output logic                  o_valid,
    output logic [pgf_pkg::QB-1:0] o_q,
    output logic                  o_ovf,
    output logic [WS-1:0]         o_side
);
    import pgf_pkg::*;

    localparam int WW = (WNUM > WDEN + QB) ? WNUM : WDEN + QB;

    logic            r_v    [QB+1];
    logic [WNUM-1:0] r_rem  [QB+1];
    logic [WDEN-1:0] r_den  [QB+1];
    logic [QB-1:0]   r_q    [QB+1];
    logic            r_ovf  [QB+1];
    logic [WS-1:0]   r_side [QB+1];

    // first stage: quotient too wide for 64 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_ovf[0]  <= WW'(i_num) >= (WW'(i_den) << QB);
        r_side[0] <= i_side;
    end

    for (genvar j = 1; j <= QB; j++) begin : g_st
        localparam int B = QB - j;
        logic [WW-1:0] shifted;
        logic          ge;

        assign shifted = WW'(r_den[j-1]) << B;
        assign ge      = WW'(r_rem[j-1]) >= shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= ge ? WNUM'(WW'(r_rem[j-1]) - shifted) : r_rem[j-1];
            r_den[j]  <= r_den[j-1];
            r_q[j]    <= r_q[j-1] | (QB'(ge) << B);
            r_ovf[j]  <= r_ovf[j-1];
            r_side[j] <= r_side[j-1];
        end
    end

    assign o_valid = r_v[QB];
    assign o_q     = r_q[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_side  = r_side[QB];

endmodule

@@ hdl/pairwise_gravity_force_unit.sv @@
// top level of the pairwise gravity force unit
`timescale 1ns / 1ps

// Computes the 2D gravitational pull of one body on another, one pair per
// cycle: force = G * own_mass * other_mass * delta / d^3 per axis, in Q32.32,
// saturated, with coincident bodies giving zero force. A beat is taken on
// every clock edge where start is high and busy is low; busy is low except
// while reset is held, so pairs can be pushed back to back without a gap.
// Pairs leave in the order they were taken, each as a one-cycle o_strobe
// beat; the result port has no ready, so the receiver must take every beat
// when it appears. The pipeline chain runs through three front stages
// (deltas and G*m, squares, sum), one stage per root bit of the distance
// (COORD_BITS+17 at COORD_BITS up to 32), four digit-serial multipliers
// (r*r, r^2*r, G*m*m, G*m*m*|delta|, 16 bits of one factor per stage), a
// 65-stage divider and the output register. The gravity constant register
// is written through the cfg channel, which is always ready; write it only
// with no pair in flight.

module pairwise_gravity_force_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pgf_pkg::t_pgf_in  i_in,
    output logic              o_strobe,
    output pgf_pkg::t_pgf_out o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [pgf_pkg::G_BITS-1:0] i_cfg_data
);
    import pgf_pkg::*;

    // coordinates are the low CW bits of each field, sign extended
    localparam int CW    = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
    localparam int DW    = CW + 1;                  // signed delta
    localparam int SW    = 2 * CW + 1;              // dx^2 + dy^2
    localparam int NW    = SW + SQ_SHIFT;           // root operand
    localparam int RW    = (NW + 1) / 2;            // distance, Q.16
    localparam int DENW  = 3 * RW;                  // r^3
    localparam int GMW   = G_BITS + 2 * MASS_BITS;  // G*m*m
    localparam int PW    = GMW + CW;                // G*m*m*|delta|
    localparam int NUMW  = PW + NUM_SHIFT;
    localparam int S0W   = G_BITS + 2 * MASS_BITS + 2 * CW + 3;
    localparam int S3W   = DENW + 2 * CW + 3;
    localparam int GM0W  = G_BITS + MASS_BITS;
    localparam int LATENCY = 3 + RW + (RW + DIG - 1) / DIG + (2 * RW + DIG - 1) / DIG
                           + (GM0W + DIG - 1) / DIG + (GMW + DIG - 1) / DIG + QB + 2;

    // gravity constant register
    logic [G_BITS-1:0] r_g;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= G_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_g <= i_cfg_data;
        end
    end

    assign busy = ~i_rst_n;

    // stage a: deltas, their magnitudes and signs, G*own_mass
    logic [CW-1:0] wx, wy, ox, oy;
    logic [DW-1:0] dx, dy, ndx, ndy;
    logic [GM0W-1:0] n_gm0;

    assign wx    = i_in.own_x[CW-1:0];
    assign wy    = i_in.own_y[CW-1:0];
    assign ox    = i_in.other_x[CW-1:0];
    assign oy    = i_in.other_y[CW-1:0];
    assign dx    = {ox[CW-1], ox} - {wx[CW-1], wx};
    assign dy    = {oy[CW-1], oy} - {wy[CW-1], wy};
    assign ndx   = -dx;
    assign ndy   = -dy;
    assign n_gm0 = r_g * i_in.own_mass;

    logic                 r_a_v;
    logic [CW-1:0]        r_a_ax, r_a_ay;
    logic                 r_a_sx, r_a_sy;
    logic [GM0W-1:0]      r_a_gm0;
    logic [MASS_BITS-1:0] r_a_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ax  <= dx[DW-1] ? ndx[CW-1:0] : dx[CW-1:0];
        r_a_ay  <= dy[DW-1] ? ndy[CW-1:0] : dy[CW-1:0];
        r_a_sx  <= dx[DW-1];
        r_a_sy  <= dy[DW-1];
        r_a_gm0 <= n_gm0;
        r_a_m1  <= i_in.other_mass;
    end

    // stage b: squares of the deltas, coincidence test
    logic                 r_b_v;
    logic [2*CW-1:0]      r_b_sqx, r_b_sqy;
    logic                 r_b_zero;
    logic [CW-1:0]        r_b_ax, r_b_ay;
    logic                 r_b_sx, r_b_sy;
    logic [GM0W-1:0]      r_b_gm0;
    logic [MASS_BITS-1:0] r_b_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sqx  <= r_a_ax * r_a_ax;
        r_b_sqy  <= r_a_ay * r_a_ay;
        r_b_zero <= (r_a_ax == '0) && (r_a_ay == '0);
        r_b_ax   <= r_a_ax;
        r_b_ay   <= r_a_ay;
        r_b_sx   <= r_a_sx;
        r_b_sy   <= r_a_sy;
        r_b_gm0  <= r_a_gm0;
        r_b_m1   <= r_a_m1;
    end

    // stage c: distance squared
    logic                 r_c_v;
    logic [SW-1:0]        r_c_s;
    logic                 r_c_zero;
    logic [CW-1:0]        r_c_ax, r_c_ay;
    logic                 r_c_sx, r_c_sy;
    logic [GM0W-1:0]      r_c_gm0;
    logic [MASS_BITS-1:0] r_c_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_s    <= SW'(r_b_sqx) + SW'(r_b_sqy);
        r_c_zero <= r_b_zero;
        r_c_ax   <= r_b_ax;
        r_c_ay   <= r_b_ay;
        r_c_sx   <= r_b_sx;
        r_c_sy   <= r_b_sy;
        r_c_gm0  <= r_b_gm0;
        r_c_m1   <= r_b_m1;
    end

    // distance in Q.16
    logic           sq_v;
    logic [RW-1:0]  sq_r;
    logic [S0W-1:0] sq_side;

    pgf_sqrt #(.WN(NW), .WS(S0W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_v),
        .i_n     ({r_c_s, {SQ_SHIFT{1'b0}}}),
        .i_side  ({r_c_gm0, r_c_m1, r_c_ax, r_c_ay, r_c_sx, r_c_sy, r_c_zero}),
        .o_valid (sq_v),
        .o_root  (sq_r),
        .o_side  (sq_side)
    );

    // r^2, then r^3
    logic              m1_v;
    logic [2*RW-1:0]   m1_p;
    logic [RW+S0W-1:0] m1_side;

    pgf_mul #(.WA(RW), .WB(RW), .WS(RW + S0W)) u_mul_r2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_a     (sq_r),
        .i_b     (sq_r),
        .i_side  ({sq_r, sq_side}),
        .o_valid (m1_v),
        .o_p     (m1_p),
        .o_side  (m1_side)
    );

    logic            m2_v;
    logic [DENW-1:0] m2_den;
    logic [S0W-1:0]  m2_side;

    pgf_mul #(.WA(2 * RW), .WB(RW), .WS(S0W)) u_mul_r3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_v),
        .i_a     (m1_p),
        .i_b     (m1_side[S0W +: RW]),
        .i_side  (m1_side[S0W-1:0]),
        .o_valid (m2_v),
        .o_p     (m2_den),
        .o_side  (m2_side)
    );

    // G*m*m
    logic           m3_v;
    logic [GMW-1:0] m3_gmm;
    logic [S3W-1:0] m3_side;

    pgf_mul #(.WA(GM0W), .WB(MASS_BITS), .WS(S3W)) u_mul_gmm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_v),
        .i_a     (m2_side[2 * CW + 3 + MASS_BITS +: GM0W]),
        .i_b     (m2_side[2 * CW + 3 +: MASS_BITS]),
        .i_side  ({m2_den, m2_side[2 * CW + 2:0]}),
        .o_valid (m3_v),
        .o_p     (m3_gmm),
        .o_side  (m3_side)
    );

    // G*m*m*|delta| per axis
    logic              m4x_v, m4y_v;
    logic [PW-1:0]     m4x_p, m4y_p;
    logic [DENW+1:0]   m4x_side;
    logic              m4y_side;

    pgf_mul #(.WA(GMW), .WB(CW), .WS(DENW + 2)) u_mul_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m3_v),
        .i_a     (m3_gmm),
        .i_b     (m3_side[3 + CW +: CW]),
        .i_side  ({m3_side[2 * CW + 3 +: DENW], m3_side[2], m3_side[0]}),
        .o_valid (m4x_v),
        .o_p     (m4x_p),
        .o_side  (m4x_side)
    );

    pgf_mul #(.WA(GMW), .WB(CW), .WS(1)) u_mul_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m3_v),
        .i_a     (m3_gmm),
        .i_b     (m3_side[3 +: CW]),
        .i_side  (m3_side[1]),
        .o_valid (m4y_v),
        .o_p     (m4y_p),
        .o_side  (m4y_side)
    );

    // magnitude = numerator / r^3, one divider per axis
    logic          dvx_v, dvy_v;
    logic [QB-1:0] dvx_q, dvy_q;
    logic          dvx_ovf, dvy_ovf;
    logic [1:0]    dvx_side;
    logic          dvy_side;

    pgf_div #(.WNUM(NUMW), .WDEN(DENW), .WS(2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m4x_v),
        .i_num   ({m4x_p, {NUM_SHIFT{1'b0}}}),
        .i_den   (m4x_side[2 +: DENW]),
        .i_side  (m4x_side[1:0]),
        .o_valid (dvx_v),
        .o_q     (dvx_q),
        .o_ovf   (dvx_ovf),
        .o_side  (dvx_side)
    );

    pgf_div #(.WNUM(NUMW), .WDEN(DENW), .WS(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m4y_v),
        .i_num   ({m4y_p, {NUM_SHIFT{1'b0}}}),
        .i_den   (m4x_side[2 +: DENW]),
        .i_side  (m4y_side),
        .o_valid (dvy_v),
        .o_q     (dvy_q),
        .o_ovf   (dvy_ovf),
        .o_side  (dvy_side)
    );

    // clip to Q32.32 and apply the sign of the delta; {clipped, value}
    function automatic logic [QB:0] clip(input logic [QB-1:0] q, input logic ovf,
                                         input logic neg);
        logic [QB-1:0] lim;
        logic [QB-1:0] mag;
        logic          sat;
        lim = neg ? F_MIN : F_MAX;
        sat = ovf || (q > lim);
        mag = sat ? lim : q;
        return {sat, neg ? -mag : mag};
    endfunction

    logic [QB:0] fx, fy;
    t_pgf_out    n_out;

    assign fx = clip(dvx_q, dvx_ovf, dvx_side[1]);
    assign fy = clip(dvy_q, dvy_ovf, dvy_side);

    always_comb begin
        if (dvx_side[0]) begin
            // coincident bodies
            n_out = '0;
        end else begin
            n_out.force_x   = fx[QB-1:0];
            n_out.force_y   = fy[QB-1:0];
            n_out.saturated = fx[QB] | fy[QB];
        end
    end

    // output register, one beat per pair
    logic     r_o_v;
    t_pgf_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= dvx_v & dvy_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_o_v;
    assign o_out    = r_out;

endmodule

@@ hdl/pgf_chk.sv @@
// port-level checks of the pairwise gravity force unit and their binding
`timescale 1ns / 1ps

module pgf_chk #(
    parameter int LAT = 139
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input pgf_pkg::t_pgf_out o_out,
    input logic              o_strobe
);
    import pgf_pkg::*;

    // reset empties the pipe
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result beat right after reset");

    // every taken pair comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("result beat missing");

    // no result beat without a pair taken that long ago
    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result beat with no pair behind it");

    // a clipped result holds a range limit on some axis
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.saturated) |->
        (o_out.force_x == F_MAX || o_out.force_x == F_MIN ||
         o_out.force_y == F_MAX || o_out.force_y == F_MIN))
        else $error("saturated flag without a limit value");

endmodule

bind pairwise_gravity_force_unit pgf_chk #(.LAT(LATENCY)) u_pgf_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_out    (o_out),
    .o_strobe (o_strobe)
);

@@ dv/pairwise_gravity_force_unit_test.sv @@
// testbench of the pairwise gravity force unit, with its own force predictor
`timescale 1ns / 1ps

// Bit-exact predictor in 256-bit arithmetic. Pairs are queued as they are
// taken, and each o_strobe beat is checked against the oldest pending force.
class grav_scoreboard;
    logic [31:0] g_const;
    pgf_pkg::t_pgf_out pending[$];
    int errors;

    function new();
        g_const = pgf_pkg::G_RESET;
        errors  = 0;
    endfunction

    // signed Q32.32 component from its delta; clips to the force range
    function logic [63:0] axis_force(logic [63:0] d, logic [255:0] gmm,
                                     logic [255:0] den, inout bit sat);
        bit neg;
        logic [255:0] absd, q;
        logic [63:0] lim, mag;
        neg  = d[63];
        absd = {192'd0, (neg ? -d : d)};
        q    = ((gmm * absd) << 56) / den;
        lim  = neg ? pgf_pkg::F_MIN : pgf_pkg::F_MAX;
        mag  = q[63:0];
        if (q[255:64] != 0 || mag > lim) begin
            sat = 1;
            mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    function pgf_pkg::t_pgf_out predict(pgf_pkg::t_pgf_in p);
        pgf_pkg::t_pgf_out f;
        logic [63:0] dx, dy, ax, ay;
        logic [255:0] dist_sq, r, cand, den, gmm;
        bit sat;
        dx = {{32{p.other_x[31]}}, p.other_x} - {{32{p.own_x[31]}}, p.own_x};
        dy = {{32{p.other_y[31]}}, p.other_y} - {{32{p.own_y[31]}}, p.own_y};
        ax = dx[63] ? -dx : dx;
        ay = dy[63] ? -dy : dy;
        dist_sq = {192'd0, ax} * {192'd0, ax} + {192'd0, ay} * {192'd0, ay};
        f   = '0;
        sat = 0;
        if (dist_sq != 0) begin
            // distance in Q.16, one root bit at a time
            r = '0;
            for (int b = 66; b >= 0; b--) begin
                cand = r | (256'd1 << b);
                if (cand * cand <= (dist_sq << 32))
                    r = cand;
            end
            den = r * r * r;
            gmm = {224'd0, g_const} * {224'd0, p.own_mass} * {224'd0, p.other_mass};
            f.force_x   = axis_force(dx, gmm, den, sat);
            f.force_y   = axis_force(dy, gmm, den, sat);
            f.saturated = sat;
        end
        return f;
    endfunction

    function void note_pair(pgf_pkg::t_pgf_in p);
        pending.push_back(predict(p));
    endfunction

    function void check_force(pgf_pkg::t_pgf_out got);
        pgf_pkg::t_pgf_out exp_f;
        if (pending.size() == 0) begin
            $error("unexpected result beat: force_x %h force_y %h",
                   got.force_x, got.force_y);
            errors++;
            return;
        end
        exp_f = pending.pop_front();
        if (got.force_x !== exp_f.force_x) begin
            $error("force_x: expected %h, got %h", exp_f.force_x, got.force_x);
            errors++;
        end
        if (got.force_y !== exp_f.force_y) begin
            $error("force_y: expected %h, got %h", exp_f.force_y, got.force_y);
            errors++;
        end
        if (got.saturated !== exp_f.saturated) begin
            $error("saturated: expected %b, got %b", exp_f.saturated, got.saturated);
            errors++;
        end
    endfunction
endclass

module pairwise_gravity_force_unit_test;
    import pgf_pkg::*;

    localparam int LATENCY    = 139;
    localparam int IDLE_LIMIT = 4000;   // cycles with no beat before giving up

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_pgf_in i_in;
    logic o_strobe;
    t_pgf_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [G_BITS-1:0] i_cfg_data;

    grav_scoreboard sb;
    int idle_cycles;

    pairwise_gravity_force_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // monitor: note taken pairs, check result beats, and run the watchdog;
    // everything here reads values from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_pair(i_in);
            if (o_strobe)
                sb.check_force(o_out);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one input beat; start stays high so the next pair can follow at once
    task automatic send_pair(t_pgf_in p);
        start <= 1'b1;
        i_in  <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // wait for every pending force, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // new gravity constant, only with nothing in flight
    task automatic write_gravity(logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.g_const = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pgf_in make_pair(logic [31:0] ox, logic [31:0] oy,
                                          logic [31:0] om, logic [31:0] tx,
                                          logic [31:0] ty, logic [31:0] tm);
        t_pgf_in p;
        p.own_x = ox; p.own_y = oy; p.own_mass = om;
        p.other_x = tx; p.other_y = ty; p.other_mass = tm;
        return p;
    endfunction

    // random pair: mostly full range, some close pairs to hit clipping,
    // some coincident pairs, some zero masses
    function automatic t_pgf_in random_pair();
        t_pgf_in p;
        int kind;
        kind = $urandom_range(0, 9);
        p.own_x = $urandom; p.own_y = $urandom;
        p.own_mass = $urandom; p.other_mass = $urandom;
        p.other_x = $urandom; p.other_y = $urandom;
        case (kind)
            0, 1, 2: begin
                // near neighbors, small offsets of either sign
                p.other_x = p.own_x + 32'($signed($urandom_range(0, 8191)) - 4096);
                p.other_y = p.own_y + 32'($signed($urandom_range(0, 8191)) - 4096);
            end
            3: begin
                p.other_x = p.own_x + 32'($signed($urandom_range(0, 2**20)) - 2**19);
                p.other_y = p.own_y + 32'($signed($urandom_range(0, 2**20)) - 2**19);
                p.own_mass = $urandom_range(0, 2**20);
            end
            4: begin
                p.other_x = p.own_x;
                p.other_y = p.own_y;
            end
            5: begin
                if ($urandom_range(0, 1)) p.own_mass = 0; else p.other_mass = 0;
            end
            default: ;
        endcase
        return p;
    endfunction

    // burst of random pairs with random gaps between bursts
    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n > 0; k++) begin
                send_pair(random_pair());
                n--;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 20));
        end
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs at the reset value of G
        send_pair(make_pair(32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                            32'h0001_0000, 32'h0002_0000, 32'h0001_0000)); // coincident
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'h0001_0000, 0, 32'hFFFF_FFFF));
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_0000, 32'hFFFF_FFFF));
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF)); // clips both
        send_pair(make_pair(32'd1, 32'd1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF)); // clips negative
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF)); // widest span
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_pair(make_pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF)); // no mass
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 0));
        send_pair(make_pair(32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
                            0, 0, 32'h0001_0000));
        send_pair(make_pair(32'hFFFF_FFFF, 0, 32'd1, 0, 32'hFFFF_FFFF, 32'd1));
        pause(3);

        // zero G, then the largest G
        write_gravity(32'd0);
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF));
        send_pair(random_pair());
        write_gravity(32'hFFFF_FFFF);
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'd1,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1));
        send_pair(make_pair(0, 0, 32'hFFFF_FFFF, 32'h0100_0000, 0, 32'hFFFF_FFFF));
        random_phase(300);

        write_gravity(G_RESET);
        random_phase(400);
        write_gravity($urandom);
        random_phase(300);
        write_gravity($urandom_range(0, 2**16));
        random_phase(300);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
